// File: sv/c8alu_pkg.sv
// Shared types and command codes for the 8-bit ALU and flag unit.
`timescale 1ns / 1ps

package c8alu_pkg;

    localparam int CMD_W  = 5;
    localparam int BYTE_W = 8;
    localparam int FLAG_W = 4;
    localparam int BIDX_W = 3;

    // flag bit positions
    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    typedef logic [CMD_W-1:0] cmd_t;

    localparam cmd_t CMD_ADD  = 5'd0;
    localparam cmd_t CMD_ADC  = 5'd1;
    localparam cmd_t CMD_SUB  = 5'd2;
    localparam cmd_t CMD_SBC  = 5'd3;
    localparam cmd_t CMD_AND  = 5'd4;
    localparam cmd_t CMD_XOR  = 5'd5;
    localparam cmd_t CMD_OR   = 5'd6;
    localparam cmd_t CMD_CP   = 5'd7;
    localparam cmd_t CMD_INC  = 5'd8;
    localparam cmd_t CMD_DEC  = 5'd9;
    localparam cmd_t CMD_RLCA = 5'd10;
    localparam cmd_t CMD_RRCA = 5'd11;
    localparam cmd_t CMD_RLA  = 5'd12;
    localparam cmd_t CMD_RRA  = 5'd13;
    localparam cmd_t CMD_DAA  = 5'd14;
    localparam cmd_t CMD_CPL  = 5'd15;
    localparam cmd_t CMD_SCF  = 5'd16;
    localparam cmd_t CMD_CCF  = 5'd17;
    localparam cmd_t CMD_BIT  = 5'd18;
    localparam cmd_t CMD_RES  = 5'd19;
    localparam cmd_t CMD_SET  = 5'd20;

    localparam logic [BYTE_W-1:0] DAA_HI_ADJ = 8'h60;
    localparam logic [BYTE_W-1:0] DAA_LO_ADJ = 8'h06;
    localparam logic [BYTE_W-1:0] DAA_HI_LIM = 8'h99;
    localparam logic [3:0]        DAA_LO_LIM = 4'h9;

    typedef struct packed {
        logic [BIDX_W-1:0] bit_index;
        logic [FLAG_W-1:0] flags_in;
        logic [BYTE_W-1:0] operand;
        logic [BYTE_W-1:0] accumulator;
        cmd_t              command;
    } in_word_t;

    typedef struct packed {
        logic              write_back;
        logic [FLAG_W-1:0] flags_out;
        logic [BYTE_W-1:0] result;
    } out_word_t;

endpackage

// File: sv/cpu8_alu_flag_unit.sv
// Top level of the 8-bit ALU and flag unit: input register, ALU, result register.
// Path: a word accepted on s_* is held in the input reg, then in the result reg, which
// drives m_*; m_tready low can hold it in the input reg until the result reg frees.
// Throughput: one word per cycle; a new word is taken whenever the input register
// is empty, or the result register is empty or is being drained in the same cycle.
// Reset: rst_n (async, active low) clears both valid bits; payload registers hold.
`timescale 1ns / 1ps

module cpu8_alu_flag_unit
    import c8alu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command[4:0], accumulator[12:5], operand[20:13], flags_in[24:21],
    // bit_index[27:25], pad[31:28] (ignored)
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // result[7:0], flags_out[11:8], write_back[12], zero pad[15:13]
    output logic [15:0] m_tdata
);

    in_word_t  in_reg;
    logic      in_valid_reg;
    out_word_t alu_out;
    out_word_t out_reg;
    logic      out_valid_reg;
    logic      out_load;
    logic      in_load;

    // pipeline advances when the result slot is free or draining
    assign out_load = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_load;
    assign in_load  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_load)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_reg <= in_word_t'(s_tdata[27:0]);
        end
        if (out_load && in_valid_reg)
        begin
            out_reg <= alu_out;
        end
    end

    c8alu_core u_core
    (
        .in_word  (in_reg),
        .out_word (alu_out)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg};

endmodule

// File: sv/c8alu_core.sv
// Combinational ALU datapath and flag logic for one command word.
`timescale 1ns / 1ps

module c8alu_core
    import c8alu_pkg::*;
(
    input  in_word_t  in_word,
    output out_word_t out_word
);

    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] v;
    logic [FLAG_W-1:0] f;
    logic              cin;
    logic              use_c;
    logic [BYTE_W:0]   sum9;
    logic [4:0]        sum_lo;
    logic [BYTE_W:0]   dif9;
    logic [4:0]        dif_lo;
    logic [BYTE_W-1:0] v_inc;
    logic [BYTE_W-1:0] v_dec;
    logic [BYTE_W-1:0] bit_mask;
    logic              daa_c;
    logic [BYTE_W-1:0] daa_r;
    logic [BYTE_W-1:0] r;
    logic [FLAG_W-1:0] nf;
    logic              wb;

    assign a   = in_word.accumulator;
    assign v   = in_word.operand;
    assign f   = in_word.flags_in;
    assign cin = f[FLAG_C];

    // carry only enters the add / subtract sums for adc / sbc
    assign use_c  = cin & ((in_word.command == CMD_ADC) || (in_word.command == CMD_SBC));
    assign sum9   = {1'b0, a} + {1'b0, v} + {{BYTE_W{1'b0}}, use_c};
    assign sum_lo = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, use_c};
    assign dif9   = {1'b0, a} - {1'b0, v} - {{BYTE_W{1'b0}}, use_c};
    assign dif_lo = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, use_c};

    assign v_inc    = v + 8'd1;
    assign v_dec    = v - 8'd1;
    assign bit_mask = 8'd1 << in_word.bit_index;

    always_comb
    begin
        daa_c = cin;
        daa_r = a;
        if (!f[FLAG_N])
        begin
            if (cin || (a > DAA_HI_LIM))
            begin
                daa_r = daa_r + DAA_HI_ADJ;
                daa_c = 1'b1;
            end
            if (f[FLAG_H] || (a[3:0] > DAA_LO_LIM))
            begin
                daa_r = daa_r + DAA_LO_ADJ;
            end
        end
        else
        begin
            if (cin)
            begin
                daa_r = daa_r - DAA_HI_ADJ;
            end
            if (f[FLAG_H])
            begin
                daa_r = daa_r - DAA_LO_ADJ;
            end
        end
    end

    always_comb
    begin
        r  = a;
        nf = f;
        wb = 1'b0;
        case (in_word.command)
            CMD_ADD, CMD_ADC:
            begin
                r  = sum9[BYTE_W-1:0];
                nf = {(sum9[BYTE_W-1:0] == 8'd0), 1'b0, sum_lo[4], sum9[BYTE_W]};
                wb = 1'b1;
            end
            CMD_SUB, CMD_SBC, CMD_CP:
            begin
                r  = dif9[BYTE_W-1:0];
                nf = {(dif9[BYTE_W-1:0] == 8'd0), 1'b1, dif_lo[4], dif9[BYTE_W]};
                wb = (in_word.command != CMD_CP);
            end
            CMD_AND:
            begin
                r  = a & v;
                nf = {((a & v) == 8'd0), 1'b0, 1'b1, 1'b0};
                wb = 1'b1;
            end
            CMD_XOR:
            begin
                r  = a ^ v;
                nf = {((a ^ v) == 8'd0), 3'b000};
                wb = 1'b1;
            end
            CMD_OR:
            begin
                r  = a | v;
                nf = {((a | v) == 8'd0), 3'b000};
                wb = 1'b1;
            end
            CMD_INC:
            begin
                r  = v_inc;
                nf = {(v_inc == 8'd0), 1'b0, (v[3:0] == 4'hf), cin};
                wb = 1'b1;
            end
            CMD_DEC:
            begin
                r  = v_dec;
                nf = {(v_dec == 8'd0), 1'b1, (v[3:0] == 4'h0), cin};
                wb = 1'b1;
            end
            CMD_RLCA:
            begin
                r  = {a[6:0], a[7]};
                nf = {3'b000, a[7]};
                wb = 1'b1;
            end
            CMD_RRCA:
            begin
                r  = {a[0], a[7:1]};
                nf = {3'b000, a[0]};
                wb = 1'b1;
            end
            CMD_RLA:
            begin
                r  = {a[6:0], cin};
                nf = {3'b000, a[7]};
                wb = 1'b1;
            end
            CMD_RRA:
            begin
                r  = {cin, a[7:1]};
                nf = {3'b000, a[0]};
                wb = 1'b1;
            end
            CMD_DAA:
            begin
                r  = daa_r;
                nf = {(daa_r == 8'd0), f[FLAG_N], 1'b0, daa_c};
                wb = 1'b1;
            end
            CMD_CPL:
            begin
                r  = ~a;
                nf = {f[FLAG_Z], 1'b1, 1'b1, cin};
                wb = 1'b1;
            end
            CMD_SCF:
            begin
                nf = {f[FLAG_Z], 2'b00, 1'b1};
            end
            CMD_CCF:
            begin
                nf = {f[FLAG_Z], 2'b00, ~cin};
            end
            CMD_BIT:
            begin
                r  = v;
                nf = {((v & bit_mask) == 8'd0), 1'b0, 1'b1, cin};
            end
            CMD_RES:
            begin
                r  = v & ~bit_mask;
                wb = 1'b1;
            end
            CMD_SET:
            begin
                r  = v | bit_mask;
                wb = 1'b1;
            end
            default:
            begin
                // unused codes: no operation
                r  = a;
                nf = f;
                wb = 1'b0;
            end
        endcase
    end

    assign out_word.result     = r;
    assign out_word.flags_out  = nf;
    assign out_word.write_back = wb;

endmodule
